@@ design/rgf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the rectified gradient filter.
// No dependencies; imported by the top level.
package rgf_pkg;

  localparam int PIX_W       = 8;
  localparam int OUT_COL_W   = 10;
  localparam int OUT_ROW_W   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_WIDTH_W = 11;
  localparam int M_TDATA_W   = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_PTR_W      = 3;
  localparam int RES_CNT_W      = 4;

  typedef struct packed {
    logic [PIX_W-1:0]     dx_neg;
    logic [PIX_W-1:0]     dx_pos;
    logic [PIX_W-1:0]     dy_neg;
    logic [PIX_W-1:0]     dy_pos;
    logic [PIX_W-1:0]     du_neg;
    logic [PIX_W-1:0]     du_pos;
    logic [PIX_W-1:0]     dv_neg;
    logic [PIX_W-1:0]     dv_pos;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 frame_last;
  } result_t;

endpackage

@@ design/rgf_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rectified_gradient_filter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the rectified gradient filter: line stores, 3x3 window, result queue.
// Depends on rgf_pkg and rgf_ram.

// Accepts one pixel per clock in raster order and returns, for each pixel, the negative
// and positive parts of its horizontal, vertical and two diagonal differences, with
// edge pixels replicated outside the image. A result for pixel (r,c) leaves when the
// pixel at (r+1,c+1) has been taken, so after each frame exactly image_width drain
// beats must follow to flush the last row. The last pixel of a row yields two results.
// Each beat reads the two line stores when accepted and updates them and the window
// in the update stage; results then wait in an eight-entry queue. The input is ready in
// every cycle while that queue has room for the results still in flight, so the
// sustained rate is one beat per clock whenever the output side takes one beat per
// clock; with a slower consumer the rate follows the consumer. Configuration writes
// are taken in any cycle and must only be made while the block is idle.
module rectified_gradient_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rgf_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
  input  logic [0:0]                      s_tuser,   // [0] drain
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] dx_neg, [15:8] dx_pos, [23:16] dy_neg, [31:24] dy_pos, [39:32] du_neg,
  // [47:40] du_pos, [55:48] dv_neg, [63:56] dv_pos, [73:64] out_col,
  // [85:74] out_row, [87:86] zero
  output logic [rgf_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tlast,   // frame_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rgf_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCW  = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;
  localparam int HCW  = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

  // Configuration registers.
  logic [CFG_WIDTH_W-1:0] image_width;
  logic [CFG_DATA_W-1:0]  image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_W'(64);
      image_height <= CFG_DATA_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data[CFG_WIDTH_W-1:0];
      end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Clamped geometry: last column index and row count.
  logic [WCW-1:0] w_ext, w_m1_ext;
  logic [HCW-1:0] h_ext, h_clamp_ext;
  logic [CW-1:0]  w_m1;
  logic [RW-1:0]  h;

  always_comb begin
    w_ext = WCW'(image_width);
    if (w_ext < WCW'(2)) begin
      w_m1_ext = WCW'(1);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_m1_ext = WCW'(MAX_WIDTH - 1);
    end else begin
      w_m1_ext = w_ext - WCW'(1);
    end
    h_ext = HCW'(image_height);
    if (h_ext < HCW'(2)) begin
      h_clamp_ext = HCW'(2);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      h_clamp_ext = HCW'(MAX_HEIGHT);
    end else begin
      h_clamp_ext = h_ext;
    end
  end

  assign w_m1 = w_m1_ext[CW-1:0];
  assign h    = h_clamp_ext[RW-1:0];

  // Input stage: position counters and line store read.
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          accept, take, flush, row_end;

  assign accept  = s_tvalid && s_tready;
  assign flush   = row_count >= h;
  assign row_end = col_count >= w_m1;
  // A drain beat before the flush row changes nothing.
  assign take    = accept && !(s_tuser[0] && !flush);

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (take) begin
      if (row_end) begin
        col_count_next = '0;
        row_count_next = flush ? '0 : row_count + RW'(1);
      end else begin
        col_count_next = col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Update stage registers.
  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [RW-1:0]    s1_row;
  logic [CW-1:0]    s1_w_m1;
  logic             s1_flush, s1_row_end, s1_top_mid;
  logic [PIX_W-1:0] s1_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col     <= col_count;
      s1_row     <= row_count;
      s1_w_m1    <= w_m1;
      s1_flush   <= flush;
      s1_row_end <= row_end;
      s1_top_mid <= row_count <= RW'(1);
      s1_pixel   <= s_tdata;
    end
  end

  logic [PIX_W-1:0] prev_rdata, prev2_rdata;
  logic [PIX_W-1:0] top_px, mid_px, bot_px;

  assign mid_px = prev_rdata;
  assign top_px = s1_top_mid ? mid_px : prev2_rdata;
  assign bot_px = s1_flush ? mid_px : s1_pixel;

  // The read happens at the accept edge and the write comes from the update stage; two
  // beats in a row never share a column, so no forwarding is needed.
  rgf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(bot_px),
    .re   (take),
    .raddr(col_count),
    .rdata(prev_rdata)
  );

  rgf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev2 (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(mid_px),
    .re   (take),
    .raddr(col_count),
    .rdata(prev2_rdata)
  );

  // 3x3 window: first index top/middle/bottom, second left/centre/right.
  logic [PIX_W-1:0] win      [3][3];
  logic [PIX_W-1:0] win_next [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = top_px;
    win_next[1][2] = mid_px;
    win_next[2][2] = bot_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  function automatic logic [2*PIX_W-1:0] rectify(input logic [PIX_W-1:0] hi,
                                                 input logic [PIX_W-1:0] lo);
    logic [PIX_W-1:0] neg, pos;
    neg = (lo > hi) ? lo - hi : '0;
    pos = (hi > lo) ? hi - lo : '0;
    return {pos, neg};
  endfunction

  // Result for the centre column, and the extra one for the row's last column,
  // where the right neighbour is the edge pixel itself.
  logic [PIX_W-1:0] la_mid, la_top, la_bot;
  result_t          res_a, res_b;
  logic             push_a, push_b;

  always_comb begin
    if (s1_col == CW'(1)) begin
      la_top = win_next[0][1];
      la_mid = win_next[1][1];
      la_bot = win_next[2][1];
    end else begin
      la_top = win_next[0][0];
      la_mid = win_next[1][0];
      la_bot = win_next[2][0];
    end
    {res_a.dx_pos, res_a.dx_neg} = rectify(win_next[1][2], la_mid);
    {res_a.dy_pos, res_a.dy_neg} = rectify(win_next[2][1], win_next[0][1]);
    {res_a.du_pos, res_a.du_neg} = rectify(win_next[2][2], la_top);
    {res_a.dv_pos, res_a.dv_neg} = rectify(win_next[0][2], la_bot);
    res_a.out_col    = OUT_COL_W'(s1_col - CW'(1));
    res_a.out_row    = OUT_ROW_W'(s1_row - RW'(1));
    res_a.frame_last = 1'b0;

    {res_b.dx_pos, res_b.dx_neg} = rectify(win_next[1][2], win_next[1][1]);
    {res_b.dy_pos, res_b.dy_neg} = rectify(win_next[2][2], win_next[0][2]);
    {res_b.du_pos, res_b.du_neg} = rectify(win_next[2][2], win_next[0][1]);
    {res_b.dv_pos, res_b.dv_neg} = rectify(win_next[0][2], win_next[2][1]);
    res_b.out_col    = OUT_COL_W'(s1_w_m1);
    res_b.out_row    = OUT_ROW_W'(s1_row - RW'(1));
    res_b.frame_last = s1_flush;
  end

  assign push_a = s1_valid && (s1_row != '0) && (s1_col != '0);
  assign push_b = s1_valid && (s1_row != '0) && s1_row_end;

  // Result queue.
  result_t              fifo [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0] count, count_next;
  logic [RES_CNT_W-1:0] n_push;
  logic                 pop;
  result_t              head;

  assign n_push = RES_CNT_W'(push_a) + RES_CNT_W'(push_b);
  assign pop    = m_tvalid && m_tready;
  assign count_next = count + n_push - RES_CNT_W'(pop);

  // Leave room for up to two results from the beat in the update stage and two more
  // from the beat accepted now.
  assign s_tready = ({1'b0, count} + (s1_valid ? (RES_CNT_W + 1)'(2) : '0))
                    <= (RES_CNT_W + 1)'(RES_FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(n_push);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      fifo[wr_ptr] <= res_a;
    end
    if (push_b) begin
      fifo[push_a ? wr_ptr + RES_PTR_W'(1) : wr_ptr] <= res_b;
    end
  end

  assign head     = fifo[rd_ptr];
  assign m_tvalid = count != '0;
  assign m_tlast  = head.frame_last;
  assign m_tdata  = {2'b00, head.out_row, head.out_col,
                     head.dv_pos, head.dv_neg, head.du_pos, head.du_neg,
                     head.dy_pos, head.dy_neg, head.dx_pos, head.dx_neg};

  // Checks.
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ({1'b0, count} + (RES_CNT_W + 1)'(n_push))
                 <= (RES_CNT_W + 1)'(RES_FIFO_DEPTH))
    else $error("results pushed into a full queue");

  a_no_same_column: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && take) |-> (col_count != s1_col))
    else $error("line store read and write hit the same column");

  a_early_drain_ignored: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser[0] && !flush) |=> (!s1_valid && $stable(col_count)
                                          && $stable(row_count)))
    else $error("early drain beat changed state");

endmodule

@@ sim/rgf_gradient_checker.sv @@
`timescale 1ns / 1ps
// Passive checker for the rectified gradient filter: predicts every result beat from the
// observed pixel and configuration beats and compares it with the output stream.
// Depends on rgf_pkg.
module rgf_gradient_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rgf_pkg::PIX_W-1:0]      s_tdata,
  input  logic [0:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [rgf_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                           m_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rgf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             results_owed
);

  import rgf_pkg::*;

  localparam int LINE_LEN     = 1024;
  localparam int ROW_LIMIT    = 4096;
  localparam int RESET_WIDTH  = 64;
  localparam int RESET_HEIGHT = 64;

  logic [CFG_WIDTH_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0]  height_reg;
  logic [PIX_W-1:0]       row_above [LINE_LEN];
  logic [PIX_W-1:0]       row_above2 [LINE_LEN];
  // Window rows are top, middle, bottom; columns are left, center, right.
  logic [PIX_W-1:0]       win [3][3];
  int unsigned            col_pos;
  int unsigned            row_pos;
  result_t                gradients_due [$];

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic result_t window_gradients(int l, int m, int r, int unsigned col,
                                               int unsigned row, logic last);
    int dx;
    int dy;
    int du;
    int dv;
    result_t g;
    dx = int'(win[1][r]) - int'(win[1][l]);
    dy = int'(win[2][m]) - int'(win[0][m]);
    du = int'(win[2][r]) - int'(win[0][l]);
    dv = int'(win[0][r]) - int'(win[2][l]);
    g.dx_neg     = (dx < 0) ? PIX_W'(-dx) : '0;
    g.dx_pos     = (dx > 0) ? PIX_W'(dx) : '0;
    g.dy_neg     = (dy < 0) ? PIX_W'(-dy) : '0;
    g.dy_pos     = (dy > 0) ? PIX_W'(dy) : '0;
    g.du_neg     = (du < 0) ? PIX_W'(-du) : '0;
    g.du_pos     = (du > 0) ? PIX_W'(du) : '0;
    g.dv_neg     = (dv < 0) ? PIX_W'(-dv) : '0;
    g.dv_pos     = (dv > 0) ? PIX_W'(dv) : '0;
    g.out_col    = OUT_COL_W'(col);
    g.out_row    = OUT_ROW_W'(row);
    g.frame_last = last;
    return g;
  endfunction

  task automatic absorb_pixel(logic [PIX_W-1:0] pix, logic drain);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    logic flush;
    logic row_end;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    w = clamp_to(width_reg, 2, LINE_LEN);
    h = clamp_to(height_reg, 2, ROW_LIMIT);
    c = col_pos;
    r = row_pos;
    flush = (r >= h);
    row_end = (c >= w - 1);
    idx = (c < LINE_LEN) ? c : LINE_LEN - 1;
    // A drain beat before the flush row changes nothing.
    if (drain && !flush) return;
    mid = row_above[idx];
    top = (r <= 1) ? mid : row_above2[idx];
    bot = flush ? mid : pix;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
    row_above2[idx] = mid;
    row_above[idx] = bot;
    if (r >= 1) begin
      if (c >= 1)
        gradients_due.insert(gradients_due.size(),
                             window_gradients((c == 1) ? 1 : 0, 1, 2, c - 1, r - 1, 1'b0));
      // The right edge pixel repeats itself as its own right neighbor.
      if (row_end)
        gradients_due.insert(gradients_due.size(),
                             window_gradients(1, 2, 2, w - 1, r - 1, flush));
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = flush ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want,
                               result_t exp);
    if (got !== want)
      report_mismatch($sformatf("%s of pixel (%0d,%0d): got %0d, expected %0d",
                                name, exp.out_row, exp.out_col, got, want));
  endtask

  task automatic check_beat();
    result_t seen;
    result_t exp;
    seen.dx_neg     = m_tdata[7:0];
    seen.dx_pos     = m_tdata[15:8];
    seen.dy_neg     = m_tdata[23:16];
    seen.dy_pos     = m_tdata[31:24];
    seen.du_neg     = m_tdata[39:32];
    seen.du_pos     = m_tdata[47:40];
    seen.dv_neg     = m_tdata[55:48];
    seen.dv_pos     = m_tdata[63:56];
    seen.out_col    = m_tdata[73:64];
    seen.out_row    = m_tdata[85:74];
    seen.frame_last = m_tlast;
    if (gradients_due.size() == 0) begin
      report_mismatch($sformatf("result beat for pixel (%0d,%0d) with nothing expected",
                                seen.out_row, seen.out_col));
      return;
    end
    exp = gradients_due.pop_front();
    compare_field("dx_neg", seen.dx_neg, exp.dx_neg, exp);
    compare_field("dx_pos", seen.dx_pos, exp.dx_pos, exp);
    compare_field("dy_neg", seen.dy_neg, exp.dy_neg, exp);
    compare_field("dy_pos", seen.dy_pos, exp.dy_pos, exp);
    compare_field("du_neg", seen.du_neg, exp.du_neg, exp);
    compare_field("du_pos", seen.du_pos, exp.du_pos, exp);
    compare_field("dv_neg", seen.dv_neg, exp.dv_neg, exp);
    compare_field("dv_pos", seen.dv_pos, exp.dv_pos, exp);
    compare_field("out_col", seen.out_col, exp.out_col, exp);
    compare_field("out_row", seen.out_row, exp.out_row, exp);
    compare_field("frame_last", seen.frame_last, exp.frame_last, exp);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatch_count = 0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      for (int i = 0; i < LINE_LEN; i++) begin
        row_above[i] = '0;
        row_above2[i] = '0;
      end
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          win[k][j] = '0;
      col_pos = 0;
      row_pos = 0;
      gradients_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_WIDTH) width_reg = cfg_data[CFG_WIDTH_W-1:0];
        else if (cfg_index == CFG_IMAGE_HEIGHT) height_reg = cfg_data;
      end
      if (s_tvalid && s_tready) absorb_pixel(s_tdata, s_tuser[0]);
    end
    results_owed <= gradients_due.size();
  end

endmodule

@@ sim/tb_rectified_gradient_filter_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the rectified gradient filter: clock, reset, pixel and configuration
// stimulus, output back-pressure and the final verdict.
// Depends on rgf_pkg, rectified_gradient_filter_unit and rgf_gradient_checker.
module tb_rectified_gradient_filter_unit;
  import rgf_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam int LINE_LEN      = 1024;
  localparam int ROW_LIMIT     = 4096;
  localparam int RANDOM_ITEMS  = 800;
  localparam int TALL_BEATS    = 24;

  // Indexes with no register behind them; writes there must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {PACE_FULL, PACE_HALF, PACE_SPARSE, PACE_MOSTLY} pace_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  hold_req = 1'b0;

  int mismatch_count;
  int results_owed;
  int unsigned cycle_count = 0;

  // Sender-side view of where the block stands in its frame.
  logic [CFG_WIDTH_W-1:0] width_shadow = 11'd64;
  logic [CFG_DATA_W-1:0]  height_shadow = 13'd64;
  int unsigned frame_col = 0;
  int unsigned frame_row = 0;
  int unsigned taken_items = 0;
  int unsigned burst_left = 0;
  bit gaps_on = 1'b1;
  bit harsh = 1'b0;

  rectified_gradient_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rgf_gradient_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output back-pressure: random pacing modes, plus one long hold-off on request.
  pace_t pace_mode = PACE_FULL;
  int unsigned pace_left = 0;
  int unsigned hold_left = 0;
  bit hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (pace_left == 0) begin
        pace_mode = pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(16, 160);
      end
      pace_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (pace_mode)
          PACE_FULL:   m_tready <= 1'b1;
          PACE_HALF:   m_tready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:     m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [PIX_W-1:0] rnd_pixel();
    if (harsh) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IMAGE_WIDTH) width_shadow = val[CFG_WIDTH_W-1:0];
    else if (idx == CFG_IMAGE_HEIGHT) height_shadow = val;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_small();
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    case ($urandom_range(0, 15))
      0:       w = CFG_DATA_W'($urandom_range(0, 1));
      1:       w = CFG_DATA_W'($urandom_range(13, 40));
      default: w = CFG_DATA_W'($urandom_range(2, 12));
    endcase
    h = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                    : CFG_DATA_W'($urandom_range(2, 6));
    configure(w, h);
  endtask

  // Stops offering beats and waits until every predicted result has left the block.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic [PIX_W-1:0] pix, logic drn);
    int unsigned gap;
    int unsigned w;
    int unsigned h;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= drn;
    do @(posedge clk); while (!s_tready);
    w = clamp_to(width_shadow, 2, LINE_LEN);
    h = clamp_to(height_shadow, 2, ROW_LIMIT);
    if (drn && frame_row < h) return;
    taken_items++;
    if (frame_col >= w - 1) begin
      frame_col = 0;
      frame_row = (frame_row >= h) ? 0 : frame_row + 1;
    end else begin
      frame_col++;
    end
  endtask

  // Runs until the block is back at the start of a frame. A non-negative abort_at
  // changes the geometry in the middle of the frame after that many beats.
  task automatic run_frame(int abort_at);
    int sent;
    sent = 0;
    do begin
      if (sent == abort_at) begin
        settle();
        configure_small();
      end
      if (frame_row >= clamp_to(height_shadow, 2, ROW_LIMIT)) begin
        // Flush row: every beat counts as a drain, whatever its flag says.
        send_item(rnd_pixel(), $urandom_range(0, 7) != 0);
      end else begin
        if ($urandom_range(0, 31) == 0) send_item(rnd_pixel(), 1'b1);
        send_item(rnd_pixel(), 1'b0);
      end
      sent++;
    end while (frame_col != 0 || frame_row != 0);
  endtask

  initial begin
    int unsigned random_base;
    bit first;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out-of-range geometry clamps to 2x2; the spare indexes must be ignored.
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(CFG_SPARE_LO, 13'h1FFF);
    write_reg(CFG_SPARE_HI, 13'h0000);
    cfg_valid <= 1'b0;

    // Smallest frame with extreme pixels, early drains, and a pixel beat in the flush row.
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hA5, 1'b0);
    send_item(8'hFF, 1'b1);
    settle();

    // Geometry changed mid-frame: the width shrinks under a running row, then the
    // height drops below the current row so the flush row starts at once.
    configure(13'd3, 13'd4);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 13'd2);
    cfg_valid <= 1'b0;
    send_item(8'h07, 1'b0);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    cfg_valid <= 1'b0;
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b1);
    settle();

    // Frame as wide as any later random geometry, sent without gaps while the output
    // side holds off for a long stretch. It writes both line stores in every column
    // that a later mid-frame change can reach.
    gaps_on = 1'b0;
    hold_req <= 1'b1;
    configure(13'd40, 13'd2);
    run_frame(-1);
    settle();

    // Tallest height at the narrowest width, cut short by a geometry change so that
    // the flush row starts at once.
    gaps_on = 1'b1;
    configure(13'd2, 13'h1FFF);
    run_frame(TALL_BEATS);

    random_base = taken_items;
    first = 1'b1;
    while (taken_items - random_base < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      harsh = ($urandom_range(0, 7) == 0);
      if (first || $urandom_range(0, 2) == 0) begin
        settle();
        configure_small();
      end
      first = 1'b0;
      run_frame(($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 20)) : -1);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
